// ===== sv/hsad_pkg.sv =====
// Shared types, constants and the per-byte average for the 2x2 ARGB downscaler.
package hsad_pkg;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;

    typedef logic [31:0] pixel_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_OUT_WIDTH  = 1'b0,
        REG_OUT_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT    = 13'd4096;
    localparam logic [HEIGHT_REG_W-1:0] LAST_ROW_AT_MAX = 13'd8191;
    localparam pixel_t                  BYTE_LSB_CLEAR  = 32'hFEFE_FEFE;

    // Line store access strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ls_ctl_t;

    // Floor average of each byte lane, no carry between lanes
    function automatic pixel_t avg_bytes(pixel_t a, pixel_t b);
        return (((a ^ b) & BYTE_LSB_CLEAR) >> 1) + (a & b);
    endfunction

endpackage

// ===== sv/hsad_line_store.sv =====
// Single-port line store holding one row of horizontal pair averages.
module hsad_line_store
    import hsad_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
)
(
    input  logic             clk,
    input  ls_ctl_t          ctl,
    input  logic [IDX_W-1:0] idx,
    input  pixel_t           wr_data,
    output pixel_t           rd_data
);

    pixel_t mem [DEPTH];
    pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[idx] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/half_scale_argb_box_downsampler_unit.sv =====
// Top level of the 2x2 box downscaler for ARGB8888 pixel streams.
//
// Source pixels arrive in raster order, one word per handshake, from a frame of
// (2 * out_width) x (2 * out_height) pixels; each output word is the per-byte
// floor average of a 2x2 block, built as avg(avg(top pair), avg(bottom pair)).
// The block takes one source pixel every clock while in_stall is low, and
// issues one output word for every fourth source pixel, on the odd column
// of each odd row, with frame_end set on the last word of the frame. Words
// pass the read stage and output register. The rate is set by the single-port line
// store: each odd-column pixel makes exactly one access to it (a write of the
// top pair average on an even row, a read of it on an odd row), so one access
// per clock is enough. The line store has no reset and needs no clearing pass;
// every entry is written on an even row before the odd row reads it. A write
// to either size register restarts the frame at its first pixel; sizes are
// saturated to 1..MAX_OUT_WIDTH and 1..4096. Write sizes only while idle.
module half_scale_argb_box_downsampler_unit
    import hsad_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  pixel_t                src_pixel,

    output logic                  out_valid,
    input  logic                  out_stall,
    output pixel_t                out_pixel,
    output logic                  frame_end
);

    localparam int IDX_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int COL_W = IDX_W + 1;
    localparam int ROW_W = HEIGHT_REG_W;

    // Frame geometry, kept as last source column / row
    logic [COL_W-1:0]        last_col_reg;
    logic [ROW_W-1:0]        last_row_reg;
    logic [COL_W-1:0]        last_col_wr;
    logic [ROW_W-1:0]        last_row_wr;
    logic [WIDTH_REG_W-1:0]  cfg_w;
    logic [HEIGHT_REG_W-1:0] cfg_h;

    // Source position
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;

    pixel_t                  held_left_reg;
    pixel_t                  pair;
    logic                    accept;
    logic                    at_frame_end;
    ls_ctl_t                 ls_ctl;
    pixel_t                  ls_rd_data;

    // Read stage: waits for the line store data
    logic                    s1_valid_reg;
    pixel_t                  s1_pair_reg;
    logic                    s1_end_reg;
    logic                    s1_adv;

    // Output register
    logic                    out_valid_reg;
    pixel_t                  out_pixel_reg;
    logic                    frame_end_reg;

    assign cfg_w = cfg_data[WIDTH_REG_W-1:0];
    assign cfg_h = cfg_data[HEIGHT_REG_W-1:0];

    // Saturate the written size and convert it to the last source index (2 * size - 1)
    always_comb
    begin
        priority if (cfg_w == '0)
        begin
            last_col_wr = COL_W'(1);
        end
        else if (32'(cfg_w) > 32'(MAX_OUT_WIDTH))
        begin
            last_col_wr = COL_W'(2 * MAX_OUT_WIDTH - 1);
        end
        else
        begin
            last_col_wr = COL_W'({cfg_w - WIDTH_REG_W'(1), 1'b1});
        end

        priority if (cfg_h == '0)
        begin
            last_row_wr = ROW_W'(1);
        end
        else if (cfg_h > HEIGHT_LIMIT)
        begin
            last_row_wr = LAST_ROW_AT_MAX;
        end
        else
        begin
            last_row_wr = ROW_W'({cfg_h - HEIGHT_REG_W'(1), 1'b1});
        end
    end

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    assign pair         = avg_bytes(held_left_reg, src_pixel);
    assign at_frame_end = (col_reg == last_col_reg) && (row_reg == last_row_reg);

    // Odd column: write the top pair on an even row, fetch it on an odd row
    assign ls_ctl.wr_en = accept && col_reg[0] && !row_reg[0];
    assign ls_ctl.rd_en = accept && col_reg[0] && row_reg[0];

    // Advance raster position, wrap at end of row and frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    hsad_line_store #(
        .DEPTH (MAX_OUT_WIDTH),
        .IDX_W (IDX_W)
    ) u_line_store (
        .clk     (clk),
        .ctl     (ls_ctl),
        .idx     (col_reg[COL_W-1:1]),
        .wr_data (pair),
        .rd_data (ls_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg  <= COL_W'(1);
            last_row_reg  <= ROW_W'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A size write restarts the frame
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_OUT_WIDTH:  last_col_reg <= last_col_wr;
                    REG_OUT_HEIGHT: last_row_reg <= last_row_wr;
                    default:        last_col_reg <= last_col_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (ls_ctl.rd_en)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept && !col_reg[0])
        begin
            held_left_reg <= src_pixel;
        end
        if (ls_ctl.rd_en)
        begin
            s1_pair_reg <= pair;
            s1_end_reg  <= at_frame_end;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_pixel_reg <= avg_bytes(ls_rd_data, s1_pair_reg);
            frame_end_reg <= s1_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== sv/hsad_checker.sv =====
// Port-level checks for the 2x2 ARGB downscaler, bound to its top level.
module hsad_checker
    import hsad_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   in_stall,
    input  logic   out_valid,
    input  logic   out_stall,
    input  pixel_t out_pixel,
    input  logic   frame_end
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(frame_end))
        else $error("output word changed while stalled");

    // Input back-pressure only comes from a stalled, full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // A new output word must trace back to an accepted source pixel
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("output word without a source pixel");

    // No back-pressure on the input while the output is empty
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output empty");

endmodule

bind half_scale_argb_box_downsampler_unit hsad_checker u_hsad_checker (.*);
